/* src/tts_pkg.sv */
// Shared types and constants for the tick task scheduler table.
`timescale 1ns / 1ps

package tts_pkg;

  // Default table size and the cap on tasks served by one dispatch
  localparam int unsigned MAX_SLOTS_DEF = 16;
  localparam int unsigned RESULT_LIMIT  = 16;
  localparam int unsigned SERVED_W      = $clog2(RESULT_LIMIT + 1);

  // Payload widths
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SLOT_W   = 8;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_ADD      = 2'd1,
    CMD_DELETE   = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_SLOT = 2'd2,
    ST_NONE_DUE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_ADD,
    S_DISPATCH,
    S_FINISH
  } seq_state_t;

  // One entry of the slot record memory
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   delay;
    logic [TIME_W-1:0]   period;
  } slot_rec_t;

  // Update of the valid and due flags of one slot
  typedef struct packed {
    logic valid_we;
    logic valid_val;
    logic due_we;
    logic due_val;
  } flag_upd_t;

endpackage

/* src/tts_slot_mem.sv */
// Slot record memory: handle, delay and period, one write and one registered read port.
`timescale 1ns / 1ps

module tts_slot_mem #(
  parameter int unsigned MAX_SLOTS = tts_pkg::MAX_SLOTS_DEF,
  parameter int unsigned IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  tts_pkg::slot_rec_t wdata,
  input  logic              re,
  input  logic [IDX_W-1:0]  raddr,
  output tts_pkg::slot_rec_t rdata
);
  import tts_pkg::*;

  slot_rec_t mem [MAX_SLOTS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/tts_seq.sv */
// Command sequencer: slot walks, valid and due flags, result register.
`timescale 1ns / 1ps

module tts_seq #(
  parameter int unsigned MAX_SLOTS = tts_pkg::MAX_SLOTS_DEF,
  parameter int unsigned IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd,
  input  logic [tts_pkg::HANDLE_W-1:0]  task_handle,
  input  logic [tts_pkg::TIME_W-1:0]    initial_delay,
  input  logic [tts_pkg::TIME_W-1:0]    repeat_period,
  input  logic [tts_pkg::SLOT_W-1:0]    slot_id,
  output logic                          result_valid,
  output logic [1:0]                    status,
  output logic [tts_pkg::SLOT_W-1:0]    slot_out,
  output logic [tts_pkg::HANDLE_W-1:0]  run_handle,
  output logic                          last,
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output tts_pkg::slot_rec_t            mem_wdata,
  output logic                          mem_re,
  output logic [IDX_W-1:0]              mem_raddr,
  input  tts_pkg::slot_rec_t            mem_rdata
);
  import tts_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);

  seq_state_t          state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic                p_valid, p_valid_next;
  logic [IDX_W-1:0]    p_idx, p_idx_next;
  logic [SERVED_W-1:0] served, served_next;
  logic                pend_valid, pend_valid_next;
  logic [IDX_W-1:0]    pend_slot, pend_slot_next;
  logic [HANDLE_W-1:0] pend_handle, pend_handle_next;

  logic [HANDLE_W-1:0] lat_handle;
  logic [TIME_W-1:0]   lat_delay;
  logic [TIME_W-1:0]   lat_period;

  logic [MAX_SLOTS-1:0] valid_bits;
  logic [MAX_SLOTS-1:0] due_bits;
  flag_upd_t            upd;
  logic [IDX_W-1:0]     upd_idx;

  logic                res_valid, res_valid_next;
  status_t             res_status, res_status_next;
  logic [SLOT_W-1:0]   res_slot, res_slot_next;
  logic [HANDLE_W-1:0] res_handle, res_handle_next;
  logic                res_last, res_last_next;

  logic accepted;
  logic rd_more;
  logic del_ok;
  logic tick_fire;

  assign busy      = (state != S_IDLE);
  assign accepted  = start && !busy;
  assign rd_more   = (cnt < CNT_W'(MAX_SLOTS));
  assign del_ok    = (slot_id < SLOT_W'(MAX_SLOTS)) && valid_bits[slot_id[IDX_W-1:0]];
  assign tick_fire = (mem_rdata.delay <= TIME_W'(1));

  assign result_valid = res_valid;
  assign status       = res_status;
  assign slot_out     = res_slot;
  assign run_handle   = res_handle;
  assign last         = res_last;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      p_valid    <= 1'b0;
      served     <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      p_valid    <= p_valid_next;
      served     <= served_next;
      pend_valid <= pend_valid_next;
      res_valid  <= res_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    p_idx       <= p_idx_next;
    pend_slot   <= pend_slot_next;
    pend_handle <= pend_handle_next;
    res_status  <= res_status_next;
    res_slot    <= res_slot_next;
    res_handle  <= res_handle_next;
    res_last    <= res_last_next;
    if (accepted) begin
      lat_handle <= task_handle;
      lat_delay  <= initial_delay;
      lat_period <= repeat_period;
    end
  end

  // Valid and due flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      due_bits   <= '0;
    end else begin
      if (upd.valid_we) begin
        valid_bits[upd_idx] <= upd.valid_val;
      end
      if (upd.due_we) begin
        due_bits[upd_idx] <= upd.due_val;
      end
    end
  end

  // Next state, memory accesses and results
  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    p_valid_next     = 1'b0;
    p_idx_next       = p_idx;
    served_next      = served;
    pend_valid_next  = pend_valid;
    pend_slot_next   = pend_slot;
    pend_handle_next = pend_handle;
    upd              = '0;
    upd_idx          = p_idx;
    mem_we           = 1'b0;
    mem_waddr        = p_idx;
    mem_wdata        = mem_rdata;
    mem_re           = 1'b0;
    mem_raddr        = cnt[IDX_W-1:0];
    res_valid_next   = 1'b0;
    res_status_next  = ST_OK;
    res_slot_next    = '0;
    res_handle_next  = '0;
    res_last_next    = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cnt_next        = '0;
          served_next     = '0;
          pend_valid_next = 1'b0;
          unique case (cmd_t'(cmd))
            CMD_TICK:     state_next = S_TICK;
            CMD_ADD:      state_next = S_ADD;
            CMD_DISPATCH: state_next = S_DISPATCH;
            CMD_DELETE: begin
              // delete completes in the accepting cycle
              res_valid_next = 1'b1;
              res_slot_next  = slot_id;
              if (del_ok) begin
                upd.valid_we    = 1'b1;
                upd.due_we      = 1'b1;
                upd_idx         = slot_id[IDX_W-1:0];
                res_status_next = ST_OK;
              end else begin
                res_status_next = ST_BAD_SLOT;
              end
            end
          endcase
        end
      end

      S_TICK: begin
        // read slot cnt while writing back slot p_idx
        if (rd_more) begin
          mem_re       = 1'b1;
          cnt_next     = cnt + CNT_W'(1);
          p_valid_next = 1'b1;
          p_idx_next   = cnt[IDX_W-1:0];
        end
        if (p_valid && valid_bits[p_idx]) begin
          mem_we = 1'b1;
          if (tick_fire) begin
            mem_wdata.delay = mem_rdata.period;
            upd.due_we      = 1'b1;
            upd.due_val     = 1'b1;
          end else begin
            mem_wdata.delay = mem_rdata.delay - TIME_W'(1);
          end
        end
        if (!rd_more && !p_valid) begin
          state_next = S_IDLE;
        end
      end

      S_ADD: begin
        // walk to the lowest free slot
        if (!rd_more) begin
          res_valid_next  = 1'b1;
          res_status_next = ST_FULL;
          res_slot_next   = SLOT_W'(MAX_SLOTS);
          state_next      = S_IDLE;
        end else if (!valid_bits[cnt[IDX_W-1:0]]) begin
          mem_we          = 1'b1;
          mem_waddr       = cnt[IDX_W-1:0];
          mem_wdata       = '{handle: lat_handle, delay: lat_delay, period: lat_period};
          upd.valid_we    = 1'b1;
          upd.valid_val   = 1'b1;
          upd.due_we      = 1'b1;
          upd_idx         = cnt[IDX_W-1:0];
          res_valid_next  = 1'b1;
          res_status_next = ST_OK;
          res_slot_next   = SLOT_W'(cnt);
          state_next      = S_IDLE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end

      S_DISPATCH: begin
        if (rd_more) begin
          mem_re       = 1'b1;
          cnt_next     = cnt + CNT_W'(1);
          p_valid_next = 1'b1;
          p_idx_next   = cnt[IDX_W-1:0];
        end
        if (p_valid && valid_bits[p_idx] && due_bits[p_idx]) begin
          // previous find goes out now; the newest is held to learn if it is last
          if (pend_valid) begin
            res_valid_next  = 1'b1;
            res_slot_next   = SLOT_W'(pend_slot);
            res_handle_next = pend_handle;
            res_last_next   = 1'b0;
          end
          pend_valid_next  = 1'b1;
          pend_slot_next   = p_idx;
          pend_handle_next = mem_rdata.handle;
          upd.due_we       = 1'b1;
          // one-shot task leaves the table
          if (mem_rdata.period == '0) begin
            upd.valid_we = 1'b1;
          end
          served_next = served + SERVED_W'(1);
          if (served == SERVED_W'(RESULT_LIMIT - 1)) begin
            p_valid_next = 1'b0;
            state_next   = S_FINISH;
          end
        end else if (!rd_more && !p_valid) begin
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        res_valid_next  = 1'b1;
        pend_valid_next = 1'b0;
        if (pend_valid) begin
          res_slot_next   = SLOT_W'(pend_slot);
          res_handle_next = pend_handle;
        end else begin
          res_status_next = ST_NONE_DUE;
        end
        state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* src/tick_task_scheduler_table_top.sv */
// Tick task scheduler table: slot record memory and command sequencer.
// Delete and add each give one result strobe, add walking to the lowest free slot or reporting
// full; tick gives no result; dispatch gives its results, the final one marked by last, at most
// one result per cycle. A new command is taken only while the sequencer is idle.
// Tick and dispatch walk the slot memory, one entry read per cycle.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Reset clears the sequencer and the valid and due flags; the record memory is not cleared.
`timescale 1ns / 1ps

module tick_task_scheduler_table_top #(
  parameter int unsigned MAX_SLOTS = tts_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd,
  input  logic [tts_pkg::HANDLE_W-1:0]  task_handle,
  input  logic [tts_pkg::TIME_W-1:0]    initial_delay,
  input  logic [tts_pkg::TIME_W-1:0]    repeat_period,
  input  logic [tts_pkg::SLOT_W-1:0]    slot_id,
  output logic                          result_valid,
  output logic [1:0]                    status,
  output logic [tts_pkg::SLOT_W-1:0]    slot_out,
  output logic [tts_pkg::HANDLE_W-1:0]  run_handle,
  output logic                          last
);
  import tts_pkg::*;

  localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_rec_t        mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  slot_rec_t        mem_rdata;

  // Sequencer
  tts_seq #(
    .MAX_SLOTS (MAX_SLOTS),
    .IDX_W     (IDX_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .task_handle   (task_handle),
    .initial_delay (initial_delay),
    .repeat_period (repeat_period),
    .slot_id       (slot_id),
    .result_valid  (result_valid),
    .status        (status),
    .slot_out      (slot_out),
    .run_handle    (run_handle),
    .last          (last),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  // Slot records
  tts_slot_mem #(
    .MAX_SLOTS (MAX_SLOTS),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
